### hdl/lbf_pkg.sv
// Shared types, codes and level clamp for the LED blink/fade controller.
package lbf_pkg;

	localparam int MAX_RES = 16;
	localparam int CNT_W = 5;
	localparam logic [7:0] FALLBACK_MAX = 8'd100;
	localparam logic [7:0] LVL_RST = 8'd0;

	localparam logic [1:0] REG_ACTIVE = 2'd0;
	localparam logic [1:0] REG_MIN    = 2'd1;
	localparam logic [1:0] REG_MAX    = 2'd2;
	localparam logic [1:0] REG_START  = 2'd3;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_BLINK    = 3'd1;
	localparam logic [2:0] OP_BSTOP    = 3'd2;
	localparam logic [2:0] OP_BREATH   = 3'd3;
	localparam logic [2:0] OP_RSTOP    = 3'd4;
	localparam logic [2:0] OP_ONE      = 3'd5;
	localparam logic [2:0] OP_ALL      = 3'd6;

	localparam logic [2:0] CC_NONE   = 3'd0;
	localparam logic [2:0] CC_BTICK  = 3'd1;
	localparam logic [2:0] CC_RTICK  = 3'd2;
	localparam logic [2:0] CC_BSTART = 3'd3;
	localparam logic [2:0] CC_BSTOP  = 3'd4;
	localparam logic [2:0] CC_RSTART = 3'd5;
	localparam logic [2:0] CC_RSTOP  = 3'd6;

	localparam logic ACT_TOGGLE = 1'b0;
	localparam logic ACT_SET    = 1'b1;

	typedef struct packed {
		logic [3:0] out_led;
		logic       action;
		logic [7:0] drive_level;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [15:0] interval;
		logic [31:0] toggles;
		logic [31:0] step;
		logic [7:0]  goal;
		logic        active;
		logic        reload;
		logic [7:0]  reload_lvl;
	} cell_cmd_t;

	typedef struct packed {
		logic       blink_fire;
		logic       ramp_fire;
		logic       emit_lvl;
		logic [7:0] new_cur;
		logic [7:0] cur;
		logic       tog_odd;
	} cell_sts_t;

	function automatic logic [7:0] clamp_lvl(input logic [7:0] v, input logic [7:0] lo_in,
		input logic [7:0] hi_in);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] r;
		lo = lo_in;
		hi = hi_in;
		if (lo > hi) begin
			lo = 8'd0;
			hi = FALLBACK_MAX;
		end
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction

endpackage

### hdl/lbf_if.sv
// Command and result channel interfaces.
interface lbf_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [3:0]  led_id;
	logic [15:0] blink_period;
	logic [31:0] duration;
	logic [7:0]  target_level;
	logic        switch_on;
	modport source(output valid, op, led_id, blink_period, duration, target_level, switch_on,
		input ready);
	modport sink(input valid, op, led_id, blink_period, duration, target_level, switch_on,
		output ready);
endinterface

interface lbf_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] out_led;
	logic       action;
	logic [7:0] drive_level;
	logic       last;
	modport source(output valid, out_led, action, drive_level, last, input ready);
	modport sink(input valid, out_led, action, drive_level, last, output ready);
endinterface

### hdl/lbf_div.sv
// Serial restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
module lbf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [31:0] quot
);
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [16:0] trial;
	logic        fit;

	assign trial = {rem_q, quo_q[31]};
	assign fit = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fit};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;
endmodule

### hdl/lbf_cell.sv
// One LED cell: blink and ramp state, visit token passed on to the next cell.
module lbf_cell #(
	parameter int TB  = 32,
	parameter int IW  = 3,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tok_load,
	input  logic                  tok_shift,
	input  logic                  tok_in,
	output logic                  tok_out,
	input  logic [IW-1:0]         id,
	input  logic [TB-1:0]         now,
	input  lbf_pkg::cell_cmd_t    cmd,
	output lbf_pkg::cell_sts_t    sts
);
	localparam int EW = (TB > 32) ? TB : 32;

	logic          tok_q;
	logic [15:0]   int_q;
	logic [31:0]   tog_q;
	logic [TB-1:0] bst_q;
	logic [31:0]   step_q;
	logic [TB-1:0] rst_q;
	logic          act_q;
	logic [7:0]    cur_q;
	logic [7:0]    goal_q;
	logic          sel;
	logic [TB-1:0] bd;
	logic [TB-1:0] rd;

	assign sel = (cmd.code == lbf_pkg::CC_BTICK || cmd.code == lbf_pkg::CC_RTICK) ? tok_q
		: (id == IW'(IDX));
	assign bd = now - bst_q;
	assign rd = now - rst_q;

	always_comb begin
		sts.blink_fire = (tog_q != '0) && (EW'(bd) >= EW'(int_q));
		sts.ramp_fire  = act_q && (EW'(rd) >= EW'(step_q));
		sts.emit_lvl   = (tog_q == '0) || tog_q[0];
		sts.cur        = cur_q;
		sts.tog_odd    = tog_q[0];
		if (goal_q > cur_q) sts.new_cur = cur_q + 8'd1;
		else if (goal_q < cur_q) sts.new_cur = cur_q - 8'd1;
		else sts.new_cur = cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (tok_load) begin
			tok_q <= (IDX == 0);
		end else if (tok_shift) begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q  <= '0;
			tog_q  <= '0;
			bst_q  <= '0;
			step_q <= '0;
			rst_q  <= '0;
			act_q  <= 1'b0;
			cur_q  <= lbf_pkg::LVL_RST;
			goal_q <= lbf_pkg::LVL_RST;
		end else if (cmd.reload) begin
			cur_q  <= cmd.reload_lvl;
			goal_q <= cmd.reload_lvl;
		end else if (sel) begin
			case (cmd.code)
				lbf_pkg::CC_BTICK: begin
					if (sts.blink_fire) begin
						tog_q <= tog_q - 32'd1;
						bst_q <= now;
					end
				end
				lbf_pkg::CC_RTICK: begin
					if (sts.ramp_fire) begin
						rst_q <= now;
						cur_q <= sts.new_cur;
						if (goal_q == cur_q) act_q <= 1'b0;
					end
				end
				lbf_pkg::CC_BSTART: begin
					int_q <= cmd.interval;
					bst_q <= now;
					tog_q <= cmd.toggles;
				end
				lbf_pkg::CC_BSTOP: tog_q <= '0;
				lbf_pkg::CC_RSTART: begin
					goal_q <= cmd.goal;
					act_q  <= cmd.active;
					rst_q  <= now;
					step_q <= cmd.step;
				end
				lbf_pkg::CC_RSTOP: begin
					goal_q <= cur_q;
					act_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign tok_out = tok_q;
endmodule

### hdl/led_blink_fade_controller_core.sv
// Top level: command sequencer, LED cell row, shared divider and result buffer.
// Tick and switch-all walk a token along the cell row, one active LED at a time;
// a tick handles each LED's blink, then its ramp. Blink and breath start wait on
// the 32-step serial divider. Results stall the walk while the output is full.
// Reset clears all LED state; levels come up at the clamped start level.
module led_blink_fade_controller_core #(
	parameter int LEDS      = 8,
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	lbf_cmd_if.sink      cmd,
	lbf_res_if.source    res,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [7:0]   cfg_data
);
	localparam int IW = (LEDS > 1) ? $clog2(LEDS) : 1;
	localparam int NW = $clog2(LEDS + 1);
	localparam int CW = (NW > 4) ? NW : 4;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CMD  = 4'd1;
	localparam logic [3:0] S_PREP = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_DONE = 4'd4;
	localparam logic [3:0] S_TB   = 4'd5;
	localparam logic [3:0] S_TR   = 4'd6;
	localparam logic [3:0] S_ALL  = 4'd7;
	localparam logic [3:0] S_ONE  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]           state_q;
	logic [3:0]           active_q;
	logic [7:0]           min_q;
	logic [7:0]           max_q;
	logic [7:0]           start_q;
	logic                 reload_q;
	logic [TIME_BITS-1:0] now_q;
	logic [2:0]           op_q;
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        idx_q;
	logic [15:0]          period_q;
	logic [31:0]          dur_q;
	logic [7:0]           tgt_q;
	logic                 on_q;
	logic [7:0]           goal_q;
	logic [7:0]           diff_q;
	logic                 pend_v_q;
	lbf_pkg::res_t        pend_q;
	logic                 ov_q;
	lbf_pkg::res_t        opay_q;
	logic [lbf_pkg::CNT_W-1:0] ev_cnt_q;

	logic [CW-1:0]        n_x;
	logic                 id_ok;
	logic                 accept;
	logic                 out_free;
	logic                 ev_v;
	lbf_pkg::res_t        ev;
	logic                 drop;
	logic                 adv;
	logic                 last_idx;
	logic [IW-1:0]        sel_idx;
	logic [IW:0]          led_num;
	logic [2:0]           code;
	lbf_pkg::cell_cmd_t   ccmd;
	lbf_pkg::cell_sts_t   sts_arr [LEDS];
	lbf_pkg::cell_sts_t   sts;
	logic [LEDS:0]        tok;
	logic                 tok_load;
	logic                 tok_shift;
	logic                 div_start;
	logic                 div_busy;
	logic [31:0]          quot;
	logic [7:0]           g_c;
	logic [7:0]           diff_c;
	logic [32:0]          bcnt;
	logic [31:0]          toggles;

	assign n_x = (CW'(active_q) < CW'(LEDS)) ? CW'(active_q) : CW'(LEDS);
	assign id_ok = (cmd.led_id != 4'd0) && (CW'(cmd.led_id) <= n_x);
	assign cmd.ready = (state_q == S_IDLE) && !reload_q;
	assign accept = cmd.valid && cmd.ready;
	assign out_free = !ov_q || res.ready;
	assign last_idx = (CW'(idx_q) + CW'(1)) == n_x;
	assign sel_idx = (state_q == S_TB || state_q == S_TR || state_q == S_ALL) ? idx_q : k_q;
	assign sts = sts_arr[sel_idx];
	assign led_num = {1'b0, sel_idx} + (IW + 1)'(1);
	assign drop = ev_cnt_q >= lbf_pkg::CNT_W'(lbf_pkg::MAX_RES);
	assign adv = !ev_v || drop || !pend_v_q || out_free;

	assign g_c = lbf_pkg::clamp_lvl(tgt_q, min_q, max_q);
	assign diff_c = (g_c > sts.cur) ? g_c - sts.cur : sts.cur - g_c;
	assign bcnt = {1'b0, quot} + 33'(quot[0] | sts.tog_odd);
	assign toggles = (bcnt == '0) ? 32'd0 : 32'(bcnt - 33'd1);

	always_comb begin
		ev_v = 1'b0;
		ev.out_led = 4'(led_num);
		ev.action = lbf_pkg::ACT_SET;
		ev.drive_level = 8'd0;
		ev.last = 1'b0;
		code = lbf_pkg::CC_NONE;
		unique case (state_q)
			S_CMD: code = (op_q == lbf_pkg::OP_BSTOP) ? lbf_pkg::CC_BSTOP : lbf_pkg::CC_RSTOP;
			S_DONE: begin
				if (op_q == lbf_pkg::OP_BLINK) begin
					ev_v = 1'b1;
					ev.action = lbf_pkg::ACT_TOGGLE;
					code = lbf_pkg::CC_BSTART;
				end else begin
					code = lbf_pkg::CC_RSTART;
				end
			end
			S_TB: begin
				ev_v = sts.blink_fire;
				ev.action = lbf_pkg::ACT_TOGGLE;
				code = lbf_pkg::CC_BTICK;
			end
			S_TR: begin
				ev_v = sts.ramp_fire && sts.emit_lvl;
				ev.drive_level = sts.new_cur;
				code = lbf_pkg::CC_RTICK;
			end
			S_ALL, S_ONE: begin
				ev_v = 1'b1;
				ev.drive_level = on_q ? sts.cur : 8'd0;
			end
			default: ;
		endcase
		ccmd.code = adv ? code : lbf_pkg::CC_NONE;
		ccmd.interval = period_q;
		ccmd.toggles = toggles;
		ccmd.step = (diff_q == 8'd0) ? dur_q : quot;
		ccmd.goal = goal_q;
		ccmd.active = dur_q != 32'd0;
		ccmd.reload = reload_q;
		ccmd.reload_lvl = lbf_pkg::clamp_lvl(start_q, min_q, max_q);
	end

	assign tok_load = accept && (cmd.op == lbf_pkg::OP_TICK || cmd.op == lbf_pkg::OP_ALL);
	assign tok_shift = adv && (state_q == S_TR || state_q == S_ALL);
	assign div_start = state_q == S_PREP;
	assign tok[0] = 1'b0;

	for (genvar i = 0; i < LEDS; i++) begin : g_cell
		lbf_cell #(.TB(TIME_BITS), .IW(IW), .IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_load  (tok_load),
			.tok_shift (tok_shift),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.id        (k_q),
			.now       (now_q),
			.cmd       (ccmd),
			.sts       (sts_arr[i])
		);
	end

	lbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dur_q),
		.divisor  ((op_q == lbf_pkg::OP_BLINK) ? period_q : {8'd0, diff_c}),
		.busy     (div_busy),
		.quot     (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			min_q    <= 8'd0;
			max_q    <= lbf_pkg::FALLBACK_MAX;
			start_q  <= 8'd0;
			reload_q <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					lbf_pkg::REG_ACTIVE: active_q <= cfg_data[3:0];
					lbf_pkg::REG_MIN: begin
						min_q <= cfg_data;
						reload_q <= 1'b1;
					end
					lbf_pkg::REG_MAX: begin
						max_q <= cfg_data;
						reload_q <= 1'b1;
					end
					lbf_pkg::REG_START: begin
						start_q <= cfg_data;
						reload_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= cmd.op;
			k_q      <= IW'(cmd.led_id - 4'd1);
			period_q <= cmd.blink_period;
			dur_q    <= cmd.duration;
			tgt_q    <= cmd.target_level;
			on_q     <= cmd.switch_on;
		end
		if (state_q == S_PREP) begin
			goal_q <= g_c;
			diff_q <= diff_c;
		end
		if (adv && ev_v && !drop) pend_q <= ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			now_q    <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			ov_q     <= 1'b0;
			opay_q   <= '0;
			ev_cnt_q <= '0;
		end else begin
			if (ov_q && res.ready) ov_q <= 1'b0;
			if (adv && ev_v && !drop) begin
				ev_cnt_q <= ev_cnt_q + lbf_pkg::CNT_W'(1);
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					ov_q   <= 1'b1;
					opay_q <= pend_q;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ev_cnt_q <= '0;
						idx_q <= '0;
						state_q <= S_FIN;
						unique case (cmd.op) inside
							lbf_pkg::OP_TICK: begin
								now_q <= now_q + TIME_BITS'(1);
								if (n_x != '0) state_q <= S_TB;
							end
							lbf_pkg::OP_BLINK:
								if (id_ok && cmd.blink_period != 16'd0) state_q <= S_PREP;
							lbf_pkg::OP_BREATH: if (id_ok) state_q <= S_PREP;
							lbf_pkg::OP_BSTOP, lbf_pkg::OP_RSTOP: if (id_ok) state_q <= S_CMD;
							lbf_pkg::OP_ONE: if (id_ok) state_q <= S_ONE;
							lbf_pkg::OP_ALL: if (n_x != '0) state_q <= S_ALL;
							default: ;
						endcase
					end
				end
				S_CMD: state_q <= S_FIN;
				S_PREP: state_q <= S_DIV;
				S_DIV: if (!div_busy) state_q <= S_DONE;
				S_DONE, S_ONE: if (adv) state_q <= S_FIN;
				S_TB: if (adv) state_q <= S_TR;
				S_TR, S_ALL: begin
					if (adv) begin
						if (last_idx) begin
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + IW'(1);
							state_q <= (state_q == S_TR) ? S_TB : S_ALL;
						end
					end
				end
				S_FIN: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						ov_q <= 1'b1;
						opay_q <= pend_q;
						opay_q.last <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid       = ov_q;
	assign res.out_led     = opay_q.out_led;
	assign res.action      = opay_q.action;
	assign res.drive_level = opay_q.drive_level;
	assign res.last        = opay_q.last;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		ev_cnt_q <= lbf_pkg::CNT_W'(lbf_pkg::MAX_RES))
		else $error("result count beyond limit");
	a_ready_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !pend_v_q)
		else $error("ready with a result still held back");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_busy)
		else $error("divider busy while idle");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && pend_v_q && out_free) |=> (ov_q && res.last))
		else $error("final transfer not presented");
endmodule

### test/tb_led_blink_fade_controller_core.sv
// Self-checking testbench for the LED blink/fade controller core.
`timescale 1ns / 1ps
module tb_led_blink_fade_controller_core;

	localparam int NLEDS = 8;
	localparam int SETTLE = 60;
	localparam int LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] OP_SPARE = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [3:0]  led_id;
		logic [15:0] blink_period;
		logic [31:0] duration;
		logic [7:0]  target_level;
		logic        switch_on;
	} led_cmd_t;

	typedef struct {
		led_cmd_t      c;
		int            n_typed;
		lbf_pkg::res_t typed;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_data;

	lbf_cmd_if cmd_ch();
	lbf_res_if res_ch();

	led_blink_fade_controller_core #(.LEDS(NLEDS), .TIME_BITS(32)) DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .res(res_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state
	logic [3:0]  n_active;
	logic [7:0]  lvl_min, lvl_max, lvl_start;
	logic [31:0] now_t;
	logic [15:0] blink_iv [NLEDS];
	logic [31:0] toggles  [NLEDS];
	logic [31:0] blink_ts [NLEDS];
	logic [31:0] ramp_iv  [NLEDS];
	logic [31:0] ramp_ts  [NLEDS];
	logic        ramp_on  [NLEDS];
	logic [7:0]  level    [NLEDS];
	logic [7:0]  goal     [NLEDS];

	lbf_pkg::res_t expected_q[$];
	int typed_n = -1;
	lbf_pkg::res_t typed_res;
	int errors = 0;
	int cycles = 0;
	bit long_hold = 0;
	bit no_idle = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] window(input logic [7:0] v);
		logic [7:0] lo, hi;
		lo = lvl_min;
		hi = lvl_max;
		if (lo > hi) begin
			lo = 0;
			hi = 8'd100;
		end
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v;
	endfunction

	function automatic void reload_levels();
		for (int i = 0; i < NLEDS; i++) begin
			level[i] = window(lvl_start);
			goal[i] = window(lvl_start);
		end
	endfunction

	function automatic void push_action(ref lbf_pkg::res_t q[$], input int i, input logic act,
		input logic [7:0] lvl);
		lbf_pkg::res_t r;
		if (q.size() >= lbf_pkg::MAX_RES) return;
		r.out_led = 4'(i + 1);
		r.action = act;
		r.drive_level = lvl;
		r.last = 1'b0;
		q.push_back(r);
	endfunction

	function automatic void tick_one(ref lbf_pkg::res_t q[$], input int i);
		if (toggles[i] != 0 && (now_t - blink_ts[i]) >= 32'(blink_iv[i])) begin
			push_action(q, i, lbf_pkg::ACT_TOGGLE, 8'd0);
			toggles[i]--;
			blink_ts[i] = now_t;
		end
		if (ramp_on[i] && (now_t - ramp_ts[i]) >= ramp_iv[i]) begin
			ramp_ts[i] = now_t;
			if (goal[i] > level[i]) level[i]++;
			else if (goal[i] < level[i]) level[i]--;
			else ramp_on[i] = 1'b0;
			if (toggles[i] == 0 || toggles[i][0])
				push_action(q, i, lbf_pkg::ACT_SET, level[i]);
		end
	endfunction

	function automatic void predict_actions(input led_cmd_t c, ref lbf_pkg::res_t q[$]);
		int n, k;
		bit ok;
		logic [32:0] cnt;
		logic [7:0] g, diff;
		n = (n_active < NLEDS) ? int'(n_active) : NLEDS;
		ok = c.led_id != 0 && int'(c.led_id) <= n;
		k = ok ? int'(c.led_id) - 1 : 0;
		unique case (c.op)
			lbf_pkg::OP_TICK: begin
				now_t++;
				for (int i = 0; i < n; i++) tick_one(q, i);
			end
			lbf_pkg::OP_BLINK: if (ok && c.blink_period != 0) begin
				cnt = 33'(c.duration / 32'(c.blink_period));
				if (cnt[0] || toggles[k][0]) cnt++;
				blink_iv[k] = c.blink_period;
				blink_ts[k] = now_t;
				push_action(q, k, lbf_pkg::ACT_TOGGLE, 8'd0);
				if (cnt > 0) cnt--;
				toggles[k] = cnt[31:0];
			end
			lbf_pkg::OP_BSTOP: if (ok) toggles[k] = 0;
			lbf_pkg::OP_BREATH: if (ok) begin
				g = window(c.target_level);
				goal[k] = g;
				ramp_on[k] = c.duration != 0;
				ramp_ts[k] = now_t;
				diff = (g > level[k]) ? g - level[k] : level[k] - g;
				ramp_iv[k] = (diff != 0) ? c.duration / 32'(diff) : c.duration;
			end
			lbf_pkg::OP_RSTOP: if (ok) begin
				goal[k] = level[k];
				ramp_on[k] = 1'b0;
			end
			lbf_pkg::OP_ONE:
				if (ok) push_action(q, k, lbf_pkg::ACT_SET, c.switch_on ? level[k] : 8'd0);
			lbf_pkg::OP_ALL: for (int i = 0; i < n; i++)
				push_action(q, i, lbf_pkg::ACT_SET, c.switch_on ? level[i] : 8'd0);
			default: ;
		endcase
		if (q.size() > 0) q[q.size() - 1].last = 1'b1;
	endfunction

	// transfers: command acceptance feeds the predictor, result transfers are checked
	always @(posedge clk) begin
		lbf_pkg::res_t q[$];
		lbf_pkg::res_t e;
		led_cmd_t c;
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			c.op = cmd_ch.op;
			c.led_id = cmd_ch.led_id;
			c.blink_period = cmd_ch.blink_period;
			c.duration = cmd_ch.duration;
			c.target_level = cmd_ch.target_level;
			c.switch_on = cmd_ch.switch_on;
			q = {};
			predict_actions(c, q);
			if (typed_n == 0) q = {};
			else if (typed_n == 1) q = '{typed_res};
			foreach (q[i]) expected_q.push_back(q[i]);
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: led %0d act %0d lvl %0d last %0d",
						res_ch.out_led, res_ch.action, res_ch.drive_level, res_ch.last);
			end else begin
				e = expected_q.pop_front();
				if (res_ch.out_led !== e.out_led || res_ch.action !== e.action ||
					res_ch.drive_level !== e.drive_level || res_ch.last !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp led %0d act %0d lvl %0d last %0d, got %0d %0d %0d %0d",
							e.out_led, e.action, e.drive_level, e.last, res_ch.out_led,
							res_ch.action, res_ch.drive_level, res_ch.last);
				end
			end
		end
	end

	// result side
	initial begin
		int g;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 0;
			end else begin
				g = no_idle ? 0 : $urandom_range(0, 9);
				if (g > 0) begin
					res_ch.ready <= 1'b0;
					repeat (g) @(negedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	task automatic send(input led_cmd_t c);
		int g;
		g = no_idle ? 0 : $urandom_range(0, 9);
		if (g > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		cmd_ch.op <= c.op;
		cmd_ch.led_id <= c.led_id;
		cmd_ch.blink_period <= c.blink_period;
		cmd_ch.duration <= c.duration;
		cmd_ch.target_level <= c.target_level;
		cmd_ch.switch_on <= c.switch_on;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			lbf_pkg::REG_ACTIVE: n_active = val[3:0];
			lbf_pkg::REG_MIN:    lvl_min = val;
			lbf_pkg::REG_MAX:    lvl_max = val;
			default:             lvl_start = val;
		endcase
		if (idx != lbf_pkg::REG_ACTIVE) reload_levels();
		@(negedge clk);
	endtask

	task automatic set_window(input logic [7:0] act, input logic [7:0] lo, input logic [7:0] hi,
		input logic [7:0] st);
		write_reg(lbf_pkg::REG_ACTIVE, act);
		write_reg(lbf_pkg::REG_MIN, lo);
		write_reg(lbf_pkg::REG_MAX, hi);
		write_reg(lbf_pkg::REG_START, st);
	endtask

	function automatic led_cmd_t mk(input logic [2:0] op, input logic [3:0] id,
		input logic [15:0] per, input logic [31:0] dur, input logic [7:0] tgt, input logic on);
		led_cmd_t c;
		c.op = op;
		c.led_id = id;
		c.blink_period = per;
		c.duration = dur;
		c.target_level = tgt;
		c.switch_on = on;
		return c;
	endfunction

	function automatic led_cmd_t random_cmd();
		led_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c.op = (r < 45) ? lbf_pkg::OP_TICK : (r < 57) ? lbf_pkg::OP_BREATH :
			(r < 67) ? lbf_pkg::OP_BLINK : (r < 72) ? lbf_pkg::OP_BSTOP :
			(r < 77) ? lbf_pkg::OP_RSTOP : (r < 87) ? lbf_pkg::OP_ONE :
			(r < 95) ? lbf_pkg::OP_ALL : (r < 97) ? OP_SPARE : 3'($urandom_range(0, 7));
		c.led_id = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		c.blink_period = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 4));
		c.duration = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
		c.target_level = 8'($urandom);
		c.switch_on = 1'($urandom);
		return c;
	endfunction

	task automatic random_run(input int n, input bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if (with_hold && i == 5) long_hold = 1;
			if (i == n / 2) begin
				cmd_ch.valid <= 1'b0;
				wait (expected_q.size() == 0);
				@(negedge clk);
			end
			send(random_cmd());
		end
		no_idle = 0;
		drain();
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = lbf_pkg::REG_ACTIVE;
		cfg_data = 8'd0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = lbf_pkg::OP_TICK;
		cmd_ch.led_id = 4'd0;
		cmd_ch.blink_period = 16'd0;
		cmd_ch.duration = 32'd0;
		cmd_ch.target_level = 8'd0;
		cmd_ch.switch_on = 1'b0;
		n_active = 0;
		lvl_min = 0;
		lvl_max = 8'd100;
		lvl_start = 0;
		now_t = 0;
		for (int i = 0; i < NLEDS; i++) begin
			blink_iv[i] = 0;
			toggles[i] = 0;
			blink_ts[i] = 0;
			ramp_iv[i] = 0;
			ramp_ts[i] = 0;
			ramp_on[i] = 0;
		end
		reload_levels();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(negedge clk);

		set_window(8'd8, 8'd0, 8'd255, 8'd0);
		rw.n_typed = 1; rw.typed = '{4'd1, lbf_pkg::ACT_SET, 8'd0, 1'b1};
		rw.c = mk(lbf_pkg::OP_ONE, 4'd1, 0, 0, 0, 1'b1); rows.push_back(rw);
		rw.n_typed = 0;
		rw.c = mk(lbf_pkg::OP_ONE, 4'd0, 0, 0, 0, 1'b1); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_ONE, 4'd15, 0, 0, 0, 1'b1); rows.push_back(rw);
		rw.c = mk(OP_SPARE, 4'd1, 16'hFFFF, '1, 8'hFF, 1'b1); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BLINK, 4'd2, 16'd0, 32'd9, 0, 1'b0); rows.push_back(rw);
		rw.n_typed = 1; rw.typed = '{4'd8, lbf_pkg::ACT_TOGGLE, 8'd0, 1'b1};
		rw.c = mk(lbf_pkg::OP_BLINK, 4'd8, 16'd1, 32'd0, 0, 1'b0); rows.push_back(rw);
		rw.n_typed = -1;
		rw.c = mk(lbf_pkg::OP_BLINK, 4'd1, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
		rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BREATH, 4'd1, 0, 32'd255, 8'd255, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BREATH, 4'd2, 0, 32'd3, 8'd0, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BREATH, 4'd3, 0, 32'd0, 8'd10, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BLINK, 4'd3, 16'd2, 32'd7, 0, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BREATH, 4'd4, 0, 32'd4, 8'd2, 1'b0); rows.push_back(rw);
		for (int i = 0; i < 5; i++) begin
			rw.c = mk(lbf_pkg::OP_TICK, 4'd0, 0, 0, 0, 1'b0); rows.push_back(rw);
		end
		rw.c = mk(lbf_pkg::OP_RSTOP, 4'd1, 0, 0, 0, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BSTOP, 4'd1, 0, 0, 0, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_ALL, 4'd0, 0, 0, 0, 1'b1); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_ALL, 4'd0, 0, 0, 0, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_BREATH, 4'd8, 16'hFFFF, 32'hFFFF_FFFF, 8'hAA, 1'b1);
		rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_ONE, 4'd4, 0, 0, 0, 1'b1); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_TICK, 4'd0, 0, 0, 0, 1'b0); rows.push_back(rw);
		rw.c = mk(lbf_pkg::OP_TICK, 4'd0, 0, 0, 0, 1'b0); rows.push_back(rw);
		foreach (rows[i]) begin
			typed_n = rows[i].n_typed;
			typed_res = rows[i].typed;
			send(rows[i].c);
		end
		typed_n = -1;
		drain();
		random_run(60, 1'b0);

		// inverted window falls back to 0..100
		set_window(8'd3, 8'd200, 8'd50, 8'd255);
		random_run(50, 1'b1);

		set_window(8'd8, 8'd10, 8'd200, 8'd128);
		random_run(60, 1'b0);

		set_window(8'd15, 8'd255, 8'd255, 8'd7);
		random_run(35, 1'b0);

		set_window(8'd0, 8'd0, 8'd0, 8'd0);
		random_run(12, 1'b0);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
hdl/lbf_pkg.sv
hdl/lbf_if.sv
hdl/lbf_div.sv
hdl/lbf_cell.sv
hdl/led_blink_fade_controller_core.sv
test/tb_led_blink_fade_controller_core.sv
